/* rtl/core/skt_pkg.sv */
package skt_pkg;

  localparam int unsigned OP_W  = 3;
  localparam int unsigned KEY_W = 32;
  localparam int unsigned QTY_W = 32;
  localparam int unsigned ST_W  = 2;
  localparam int unsigned POS_W = 6;
  localparam int unsigned CNT_W = 7;

  // one table row as stored: key in the upper half, quantity in the lower
  localparam int unsigned ROW_W = KEY_W + QTY_W;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_SEARCH = 3'd1,
    OP_UPDATE = 3'd2,
    OP_REMOVE = 3'd3,
    OP_CLEAR  = 3'd4
  } op_e;

  typedef enum logic [ST_W-1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_DUP  = 2'd2,
    STAT_MISS = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EXEC,
    ST_MOVE,
    ST_DONE
  } state_e;

endpackage

/* rtl/core/skt_ram.sv */
module skt_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/sorted_key_table.sv */
// sorted key table: up to CAPACITY entries of signed key and signed quantity,
// always held in ascending key order in one row memory.
// input channel (in_valid_i / in_ready_o) carries opcode_i, part_key_i and
// amount_i; output channel (out_valid_o / out_ready_i) carries status_o,
// quantity_o, position_o and entry_count_o, exactly one transfer per input.
// an operation walks the rows one per cycle through a single compare unit
// until it meets the first key not below part_key_i, then insert and remove
// move the rows past that point one per cycle through the memory port. the
// slowest items are an insert into a table one short of full and a remove
// from a full table; clear, full insert and unused opcodes skip the scan and
// the move and go straight to the result.
// in_ready_o is high only while no operation is in flight.
// reset empties the table at once: the row memory is not cleared, rows at or
// above the entry count are simply never used.
// a finished result sits in the output register until taken; a new item is
// accepted meanwhile, and it waits in its last step if its result is ready
// before the previous one was taken.
module sorted_key_table #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [skt_pkg::OP_W-1:0]            opcode_i,
  input  logic signed [skt_pkg::KEY_W-1:0]    part_key_i,
  input  logic signed [skt_pkg::QTY_W-1:0]    amount_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [skt_pkg::ST_W-1:0]            status_o,
  output logic signed [skt_pkg::QTY_W-1:0]    quantity_o,
  output logic [skt_pkg::POS_W-1:0]           position_o,
  output logic [skt_pkg::CNT_W-1:0]           entry_count_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CapCount = CW'(CAPACITY);

  // control state
  skt_pkg::state_e state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   iss_q, iss_d;      // next row to read while scanning
  logic            have_q, have_d;    // read data holds row cmp_q
  logic [AW-1:0]   cmp_q, cmp_d;
  logic [CW-1:0]   rem_q, rem_d;      // rows left to read while moving
  logic [AW-1:0]   ptr_q, ptr_d;
  logic            pend_q, pend_d;    // read data waits to be written back
  logic [AW-1:0]   pend_addr_q, pend_addr_d;
  logic            out_valid_q, out_valid_d;

  // operation payload
  skt_pkg::op_e                    op_q, op_d;
  logic signed [skt_pkg::KEY_W-1:0] key_q, key_d;
  logic signed [skt_pkg::QTY_W-1:0] amt_q, amt_d;
  logic                            hit_q, hit_d;
  logic [AW-1:0]                   pos_q, pos_d;
  logic signed [skt_pkg::QTY_W-1:0] fqty_q, fqty_d;

  // pending result and output register
  skt_pkg::status_e                 r_status_q, r_status_d;
  logic signed [skt_pkg::QTY_W-1:0] r_qty_q, r_qty_d;
  logic [AW-1:0]                    r_pos_q, r_pos_d;
  skt_pkg::status_e                 o_status_q, o_status_d;
  logic signed [skt_pkg::QTY_W-1:0] o_qty_q, o_qty_d;
  logic [AW-1:0]                    o_pos_q, o_pos_d;
  logic [CW-1:0]                    o_cnt_q, o_cnt_d;

  // row memory port
  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic [skt_pkg::ROW_W-1:0] ram_wdata;
  logic [AW-1:0]            ram_raddr;
  logic [skt_pkg::ROW_W-1:0] ram_rdata;

  logic signed [skt_pkg::KEY_W-1:0] rd_key;
  logic signed [skt_pkg::QTY_W-1:0] rd_qty;
  logic                             key_ge;
  logic signed [skt_pkg::QTY_W-1:0] upd_sum;
  logic                             in_xfer;

  skt_ram #(
    .Width (skt_pkg::ROW_W),
    .Depth (CAPACITY)
  ) u_rows (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_key  = ram_rdata[skt_pkg::ROW_W-1:skt_pkg::QTY_W];
  assign rd_qty  = ram_rdata[skt_pkg::QTY_W-1:0];
  // the shared compare: first stored key not below the searched one
  assign key_ge  = rd_key >= key_q;
  assign upd_sum = fqty_q + amt_q;   // wraps at 32 bits

  assign in_ready_o = (state_q == skt_pkg::ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    iss_d       = iss_q;
    have_d      = have_q;
    cmp_d       = cmp_q;
    rem_d       = rem_q;
    ptr_d       = ptr_q;
    pend_d      = pend_q;
    pend_addr_d = pend_addr_q;
    out_valid_d = out_valid_q;
    op_d        = op_q;
    key_d       = key_q;
    amt_d       = amt_q;
    hit_d       = hit_q;
    pos_d       = pos_q;
    fqty_d      = fqty_q;
    r_status_d  = r_status_q;
    r_qty_d     = r_qty_q;
    r_pos_d     = r_pos_q;
    o_status_d  = o_status_q;
    o_qty_d     = o_qty_q;
    o_pos_d     = o_pos_q;
    o_cnt_d     = o_cnt_q;
    ram_we      = 1'b0;
    ram_waddr   = pend_addr_q;
    ram_wdata   = ram_rdata;
    ram_raddr   = ptr_q;

    // output register drains independently of the sequencer
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      skt_pkg::ST_IDLE: begin
        if (in_xfer) begin
          op_d       = skt_pkg::op_e'(opcode_i);
          key_d      = part_key_i;
          amt_d      = amount_i;
          iss_d      = '0;
          have_d     = 1'b0;
          r_status_d = skt_pkg::STAT_OK;
          r_qty_d    = '0;
          r_pos_d    = '0;
          priority if (opcode_i == skt_pkg::OP_INSERT && count_q >= CapCount) begin
            r_status_d = skt_pkg::STAT_FULL;
            state_d    = skt_pkg::ST_DONE;
          end else if (opcode_i == skt_pkg::OP_INSERT || opcode_i == skt_pkg::OP_SEARCH ||
                       opcode_i == skt_pkg::OP_UPDATE || opcode_i == skt_pkg::OP_REMOVE) begin
            state_d = skt_pkg::ST_SCAN;
          end else if (opcode_i == skt_pkg::OP_CLEAR) begin
            count_d = '0;
            state_d = skt_pkg::ST_DONE;
          end else begin
            // unused opcodes leave the table alone
            state_d = skt_pkg::ST_DONE;
          end
        end
      end

      skt_pkg::ST_SCAN: begin
        ram_raddr = iss_q[AW-1:0];
        fqty_d    = rd_qty;
        if (have_q && key_ge) begin
          hit_d   = (rd_key == key_q);
          pos_d   = cmp_q;
          state_d = skt_pkg::ST_EXEC;
        end else if (iss_q >= count_q) begin
          // every row is below the key: it would go at the end
          hit_d   = 1'b0;
          pos_d   = AW'(count_q);
          state_d = skt_pkg::ST_EXEC;
        end else begin
          have_d = 1'b1;
          cmp_d  = iss_q[AW-1:0];
          iss_d  = iss_q + CW'(1);
        end
      end

      skt_pkg::ST_EXEC: begin
        state_d = skt_pkg::ST_DONE;
        pend_d  = 1'b0;
        unique case (op_q)
          skt_pkg::OP_INSERT: begin
            if (hit_q) begin
              r_status_d = skt_pkg::STAT_DUP;
              r_qty_d    = fqty_q;
              r_pos_d    = pos_q;
            end else begin
              // shift rows pos..count-1 up by one, from the top down
              rem_d   = count_q - CW'(pos_q);
              ptr_d   = AW'(count_q - CW'(1));
              state_d = skt_pkg::ST_MOVE;
            end
          end
          skt_pkg::OP_SEARCH: begin
            if (hit_q) begin
              r_qty_d = fqty_q;
              r_pos_d = pos_q;
            end else begin
              r_status_d = skt_pkg::STAT_MISS;
            end
          end
          skt_pkg::OP_UPDATE: begin
            if (hit_q) begin
              ram_we    = 1'b1;
              ram_waddr = pos_q;
              ram_wdata = {key_q, upd_sum};
              r_qty_d   = upd_sum;
              r_pos_d   = pos_q;
            end else begin
              r_status_d = skt_pkg::STAT_MISS;
            end
          end
          skt_pkg::OP_REMOVE: begin
            if (hit_q) begin
              // close the gap: rows pos+1..count-1 move down by one
              r_pos_d = pos_q;
              rem_d   = count_q - CW'(pos_q) - CW'(1);
              ptr_d   = pos_q + AW'(1);
              state_d = skt_pkg::ST_MOVE;
            end else begin
              r_status_d = skt_pkg::STAT_MISS;
            end
          end
          default: begin
          end
        endcase
      end

      skt_pkg::ST_MOVE: begin
        // read one row per cycle, write the previous read back one place over
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = (op_q == skt_pkg::OP_INSERT) ? pend_addr_q + AW'(1)
                                                   : pend_addr_q - AW'(1);
          ram_wdata = ram_rdata;
        end
        if (rem_q != '0) begin
          pend_d      = 1'b1;
          pend_addr_d = ptr_q;
          ptr_d       = (op_q == skt_pkg::OP_INSERT) ? ptr_q - AW'(1) : ptr_q + AW'(1);
          rem_d       = rem_q - CW'(1);
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            if (op_q == skt_pkg::OP_INSERT) begin
              ram_we    = 1'b1;
              ram_waddr = pos_q;
              ram_wdata = {key_q, amt_q};
              count_d   = count_q + CW'(1);
              r_qty_d   = amt_q;
              r_pos_d   = pos_q;
            end else begin
              count_d = count_q - CW'(1);
            end
            state_d = skt_pkg::ST_DONE;
          end
        end
      end

      skt_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          o_status_d  = r_status_q;
          o_qty_d     = r_qty_q;
          o_pos_d     = r_pos_q;
          o_cnt_d     = count_q;
          out_valid_d = 1'b1;
          state_d     = skt_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = skt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= skt_pkg::ST_IDLE;
      count_q     <= '0;
      iss_q       <= '0;
      have_q      <= 1'b0;
      rem_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      iss_q       <= iss_d;
      have_q      <= have_d;
      rem_q       <= rem_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    cmp_q       <= cmp_d;
    ptr_q       <= ptr_d;
    pend_addr_q <= pend_addr_d;
    op_q        <= op_d;
    key_q       <= key_d;
    amt_q       <= amt_d;
    hit_q       <= hit_d;
    pos_q       <= pos_d;
    fqty_q      <= fqty_d;
    r_status_q  <= r_status_d;
    r_qty_q     <= r_qty_d;
    r_pos_q     <= r_pos_d;
    o_status_q  <= o_status_d;
    o_qty_q     <= o_qty_d;
    o_pos_q     <= o_pos_d;
    o_cnt_q     <= o_cnt_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = o_status_q;
  assign quantity_o    = o_qty_q;
  assign position_o    = skt_pkg::POS_W'(o_pos_q);
  assign entry_count_o = skt_pkg::CNT_W'(o_cnt_q);

endmodule

/* verif/sorted_key_table_tb.sv */
// sorted key table testbench: a shadow copy of the table predicts every
// status, quantity, position and entry count, and each output transfer is
// compared with the oldest prediction still waiting
module sorted_key_table_tb;

  localparam int unsigned TABLE_DEPTH  = 64;
  localparam int unsigned ITEM_TARGET  = 1500;
  // receiver hold-off long enough to back the block up into its input
  localparam int unsigned HOLD_CYCLES  = 500;
  localparam int unsigned HOLD_AFTER   = 200;
  // worst item is one pass over every row plus the hand-off, with margin
  localparam int unsigned DRAIN_CYCLES = 2 * TABLE_DEPTH + 16;
  localparam int unsigned LIMIT_CYCLES = 1_500_000;

  // opcodes the block ignores
  localparam logic [skt_pkg::OP_W-1:0] OP_FIRST_UNUSED =
    skt_pkg::OP_W'(skt_pkg::OP_CLEAR + 1);
  localparam logic [skt_pkg::OP_W-1:0] OP_LAST_UNUSED  = '1;

  typedef struct packed {
    logic [skt_pkg::ST_W-1:0]         status;
    logic signed [skt_pkg::QTY_W-1:0] quantity;
    logic [skt_pkg::POS_W-1:0]        position;
    logic [skt_pkg::CNT_W-1:0]        count;
  } reply_t;

  // shadow table plus the queue of replies it predicts
  class key_table_scoreboard;
    logic signed [skt_pkg::KEY_W-1:0] shadow_keys [TABLE_DEPTH];
    logic signed [skt_pkg::QTY_W-1:0] shadow_qtys [TABLE_DEPTH];
    int unsigned                      shadow_count = 0;
    reply_t                           expected_replies [$];
    int unsigned                      delivered = 0;
    int unsigned                      mismatches = 0;

    function int unsigned entries();
      return shadow_count;
    endfunction

    function int unsigned pending();
      return expected_replies.size();
    endfunction

    function logic signed [skt_pkg::KEY_W-1:0] any_stored_key();
      if (shadow_count == 0) return $urandom;
      return shadow_keys[$urandom_range(shadow_count - 1)];
    endfunction

    // apply one accepted request to the shadow table and queue its reply
    function void note_request(logic [skt_pkg::OP_W-1:0] op,
                               logic signed [skt_pkg::KEY_W-1:0] key,
                               logic signed [skt_pkg::QTY_W-1:0] amt);
      reply_t r;
      int     hit;
      int     slot;
      r   = '0;
      hit = -1;
      for (int i = 0; i < shadow_count; i++)
        if (shadow_keys[i] == key) hit = i;
      case (op)
        skt_pkg::OP_INSERT: begin
          // fullness wins over the duplicate test
          if (shadow_count >= TABLE_DEPTH) begin
            r.status = skt_pkg::STAT_FULL;
          end else if (hit >= 0) begin
            r.status   = skt_pkg::STAT_DUP;
            r.position = skt_pkg::POS_W'(hit);
            r.quantity = shadow_qtys[hit];
          end else begin
            slot = 0;
            while (slot < shadow_count && shadow_keys[slot] < key) slot++;
            for (int s = shadow_count; s > slot; s--) begin
              shadow_keys[s] = shadow_keys[s-1];
              shadow_qtys[s] = shadow_qtys[s-1];
            end
            shadow_keys[slot] = key;
            shadow_qtys[slot] = amt;
            shadow_count++;
            r.position = skt_pkg::POS_W'(slot);
            r.quantity = amt;
          end
        end
        skt_pkg::OP_SEARCH, skt_pkg::OP_UPDATE: begin
          if (hit < 0) begin
            r.status = skt_pkg::STAT_MISS;
          end else begin
            // update wraps at the quantity width
            if (op == skt_pkg::OP_UPDATE) shadow_qtys[hit] = shadow_qtys[hit] + amt;
            r.position = skt_pkg::POS_W'(hit);
            r.quantity = shadow_qtys[hit];
          end
        end
        skt_pkg::OP_REMOVE: begin
          if (hit < 0) begin
            r.status = skt_pkg::STAT_MISS;
          end else begin
            for (int s = hit; s + 1 < shadow_count; s++) begin
              shadow_keys[s] = shadow_keys[s+1];
              shadow_qtys[s] = shadow_qtys[s+1];
            end
            shadow_count--;
            r.position = skt_pkg::POS_W'(hit);
          end
        end
        skt_pkg::OP_CLEAR: shadow_count = 0;
        default: ;
      endcase
      r.count = skt_pkg::CNT_W'(shadow_count);
      expected_replies.push_back(r);
    endfunction

    function void check_reply(logic [skt_pkg::ST_W-1:0] st,
                              logic signed [skt_pkg::QTY_W-1:0] qty,
                              logic [skt_pkg::POS_W-1:0] pos,
                              logic [skt_pkg::CNT_W-1:0] cnt);
      reply_t want;
      delivered++;
      if (expected_replies.size() == 0) begin
        $display("%0t: reply with nothing outstanding (status %0d qty %0d pos %0d cnt %0d)",
                 $realtime, st, qty, pos, cnt);
        mismatches++;
        return;
      end
      want = expected_replies.pop_front();
      if (st !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $realtime, want.status, st);
        mismatches++;
      end
      if (qty !== want.quantity) begin
        $display("%0t: quantity expected %0d actual %0d", $realtime, want.quantity, qty);
        mismatches++;
      end
      if (pos !== want.position) begin
        $display("%0t: position expected %0d actual %0d", $realtime, want.position, pos);
        mismatches++;
      end
      if (cnt !== want.count) begin
        $display("%0t: entry count expected %0d actual %0d", $realtime, want.count, cnt);
        mismatches++;
      end
    endfunction
  endclass

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             in_valid_i = 1'b0;
  logic                             in_ready_o;
  logic [skt_pkg::OP_W-1:0]         opcode_i = skt_pkg::OP_SEARCH;
  logic signed [skt_pkg::KEY_W-1:0] part_key_i = '0;
  logic signed [skt_pkg::QTY_W-1:0] amount_i = '0;
  logic                             out_valid_o;
  logic                             out_ready_i = 1'b0;
  logic [skt_pkg::ST_W-1:0]         status_o;
  logic signed [skt_pkg::QTY_W-1:0] quantity_o;
  logic [skt_pkg::POS_W-1:0]        position_o;
  logic [skt_pkg::CNT_W-1:0]        entry_count_o;

  key_table_scoreboard sb = new();
  int unsigned         items_sent = 0;
  int unsigned         cycle_count = 0;

  sorted_key_table #(
    .CAPACITY(TABLE_DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .opcode_i     (opcode_i),
    .part_key_i   (part_key_i),
    .amount_i     (amount_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .quantity_o   (quantity_o),
    .position_o   (position_o),
    .entry_count_o(entry_count_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // watchdog on the whole run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // every output transfer is checked at the edge that completes it
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_reply(status_o, quantity_o, position_o, entry_count_o);
  end

  // receiver side: random stalls, some long, some quiet stretches, and one
  // long hold-off so the block fills its output and blocks the input
  initial begin
    int unsigned stall_left;
    int unsigned quiet_left;
    int unsigned r;
    bit          hold_done;
    stall_left = 0;
    quiet_left = 0;
    hold_done  = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        out_ready_i = 1'b0;
        stall_left--;
      end else if (!hold_done && sb.delivered >= HOLD_AFTER) begin
        hold_done   = 1'b1;
        stall_left  = HOLD_CYCLES - 1;
        out_ready_i = 1'b0;
      end else if (quiet_left > 0) begin
        out_ready_i = 1'b1;
        quiet_left--;
      end else begin
        r = $urandom_range(99);
        if (r < 55) begin
          out_ready_i = 1'b1;
        end else if (r < 85) begin
          out_ready_i = 1'b0;
          stall_left  = $urandom_range(2);
        end else if (r < 90) begin
          out_ready_i = 1'b0;
          stall_left  = $urandom_range(60, 20);
        end else begin
          out_ready_i = 1'b1;
          quiet_left  = $urandom_range(100, 30);
        end
      end
    end
  end

  // drop valid between transfers; the argument sets the length of the gap
  task automatic idle(input int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
    end
  endtask

  // offer one request and hold it until the block takes it
  task automatic send(input logic [skt_pkg::OP_W-1:0] op,
                      input logic signed [skt_pkg::KEY_W-1:0] key,
                      input logic signed [skt_pkg::QTY_W-1:0] amt);
    @(negedge clk_i);
    in_valid_i = 1'b1;
    opcode_i   = op;
    part_key_i = key;
    amount_i   = amt;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(op, key, amt);
    items_sent++;
  endtask

  // sender holds off until every reply is back
  task automatic wait_drained();
    idle(1);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  // mostly keys already stored, some near zero, some anywhere
  function automatic logic signed [skt_pkg::KEY_W-1:0] pick_key();
    int unsigned r;
    int          near;
    r = $urandom_range(99);
    if (r < 70 && sb.entries() > 0) return sb.any_stored_key();
    if (r < 90) begin
      near = $urandom_range(80);
      return near - 40;
    end
    return $urandom;
  endfunction

  function automatic logic signed [skt_pkg::QTY_W-1:0] pick_amount();
    int unsigned r;
    int          near;
    r = $urandom_range(99);
    if (r < 10) begin
      case ($urandom_range(3))
        0:       return 32'sh8000_0000;
        1:       return 32'sh7fff_ffff;
        2:       return '0;
        default: return -1;
      endcase
    end
    if (r < 25) begin
      near = $urandom_range(20);
      return near - 10;
    end
    return $urandom;
  endfunction

  function automatic logic [skt_pkg::OP_W-1:0] pick_op();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 30) return skt_pkg::OP_INSERT;
    if (r < 50) return skt_pkg::OP_SEARCH;
    if (r < 70) return skt_pkg::OP_UPDATE;
    if (r < 92) return skt_pkg::OP_REMOVE;
    if (r < 95) return skt_pkg::OP_CLEAR;
    return skt_pkg::OP_W'($urandom_range(OP_LAST_UNUSED, OP_FIRST_UNUSED));
  endfunction

  initial begin
    int unsigned round;
    int unsigned mode;
    int unsigned n;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // lookups on an empty table miss
    send(skt_pkg::OP_SEARCH, 5, 0);
    send(skt_pkg::OP_REMOVE, 5, 0);
    send(skt_pkg::OP_UPDATE, 5, 1);
    // key extremes, the inserts landing in an empty table, at the end, in front and between others
    send(skt_pkg::OP_INSERT, 0, 10);
    send(skt_pkg::OP_INSERT, 32'sh7fff_ffff, 32'sh7fff_ffff);
    send(skt_pkg::OP_INSERT, 32'sh8000_0000, 32'sh8000_0000);
    idle(3);
    send(skt_pkg::OP_INSERT, -1, -1);
    // duplicate key reports the stored entry, table unchanged
    send(skt_pkg::OP_INSERT, 0, 99);
    send(skt_pkg::OP_SEARCH, 32'sh7fff_ffff, 0);
    // update wraps past both ends of the quantity range
    send(skt_pkg::OP_UPDATE, 32'sh7fff_ffff, 1);
    send(skt_pkg::OP_UPDATE, 32'sh8000_0000, 32'sh8000_0000);
    send(skt_pkg::OP_UPDATE, -1, 32'sh7fff_ffff);
    // removal from the middle, the front and the back
    send(skt_pkg::OP_REMOVE, 0, 0);
    send(skt_pkg::OP_REMOVE, 32'sh8000_0000, 0);
    send(skt_pkg::OP_REMOVE, 32'sh7fff_ffff, 0);
    // ignored opcodes leave the count alone
    for (int op = OP_FIRST_UNUSED; op <= OP_LAST_UNUSED; op++)
      send(skt_pkg::OP_W'(op), $urandom, $urandom);
    send(skt_pkg::OP_SEARCH, -1, 0);
    send(skt_pkg::OP_CLEAR, -1, 0);
    send(skt_pkg::OP_SEARCH, -1, 0);
    send(skt_pkg::OP_INSERT, 7, 0);
    send(skt_pkg::OP_CLEAR, 0, 0);

    round = 0;
    while (items_sent < ITEM_TARGET) begin
      if (round % 4 == 3) wait_drained();
      mode = $urandom_range(9);
      if (mode < 3) begin
        // fill the table to capacity, then push inserts against a full table
        n = 0;
        while (sb.entries() < TABLE_DEPTH && n < 160) begin
          idle(pick_gap());
          send(skt_pkg::OP_INSERT, ($urandom_range(3) == 0) ? pick_key() : $urandom,
               pick_amount());
          n++;
        end
        repeat (6) begin
          idle(pick_gap());
          send(skt_pkg::OP_INSERT, pick_key(), pick_amount());
        end
      end else if (mode < 9) begin
        // mixed traffic on mostly stored keys
        repeat (40) begin
          idle(pick_gap());
          send(pick_op(), pick_key(), pick_amount());
        end
      end else begin
        // run the table down with removals
        repeat (30) begin
          idle(pick_gap());
          send(skt_pkg::OP_REMOVE, pick_key(), pick_amount());
        end
      end
      round++;
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
